FILE: hw/rtl/kfh_pkg.sv
package kfh_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_KMER_LEN_DEF = 8;
  localparam int COUNT_BITS_DEF   = 32;

  // Fixed field widths of the streaming interface.
  localparam int KMER_LEN_W  = 4;
  localparam int REQ_W       = 2;
  localparam int QUERY_W     = 16;
  localparam int RESULT_W    = 32;

  localparam logic [KMER_LEN_W-1:0] KMER_LEN_RESET = 4'd8;

  typedef enum logic [REQ_W-1:0] {
    REQ_BASE  = 2'd0,
    REQ_EOS   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  // Table operation issued for one accepted item.
  typedef struct packed {
    logic inc;
    logic query;
  } tbl_op_t;

endpackage

FILE: hw/rtl/kmer_frequency_histogram.sv
// A query's count goes from the table into the result queue that drives out_tvalid.
// Throughput: one item per cycle while in_tready is high; the count table is a
// one-port-read, one-port-write memory, and a read-modify-write collision with the
// previous item is forwarded. Reset: rst_n (synchronous) clears control state, then a
// clearing pass writes zero to each of the 4**MAX_KMER_LEN table entries, one per
// cycle; in_tready stays low meanwhile, but configuration writes are taken as usual.
module kmer_frequency_histogram #(
  parameter int MAX_KMER_LEN = kfh_pkg::MAX_KMER_LEN_DEF,
  parameter int COUNT_BITS   = kfh_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input items.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: base_code[1:0], base_invalid[2], query_kmer[18:3], zero pad [23:19]
  input  logic [23:0]                    in_tdata,
  // tuser: req_type[1:0]
  input  logic [kfh_pkg::REQ_W-1:0]      in_tuser,
  // Result items.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata: kmer_count[31:0]
  output logic [kfh_pkg::RESULT_W-1:0]   out_tdata,
  // Configuration: kmer_len.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kfh_pkg::KMER_LEN_W-1:0] cfg_data
);

  localparam int ADDR_W = 2 * MAX_KMER_LEN;

  logic                           in_accept;
  logic [kfh_pkg::KMER_LEN_W-1:0] kmer_len_r;

  // Table clearing pass after reset.
  logic                           clr_busy_r;
  logic [ADDR_W-1:0]              clr_addr_r;

  // Front end: window and run tracking, table index for this item.
  kfh_pkg::tbl_op_t               op;
  logic [ADDR_W-1:0]              idx;

  // Second stage: table data is back, modify and write.
  logic                           s1_inc_r;
  logic                           s1_query_r;
  logic [ADDR_W-1:0]              s1_idx_r;
  logic                           fwd_hit_r;
  logic [COUNT_BITS-1:0]          fwd_data_r;

  logic                           wr_en;
  logic [ADDR_W-1:0]              wr_addr;
  logic [COUNT_BITS-1:0]          wr_data;
  logic                           rd_en;
  logic [COUNT_BITS-1:0]          rd_data;
  logic [COUNT_BITS-1:0]          cur_count;
  logic [COUNT_BITS-1:0]          inc_count;
  logic [COUNT_BITS+31:0]         count_ext;
  logic [kfh_pkg::RESULT_W-1:0]   result;

  logic [1:0]                     q_level;
  logic [2:0]                     q_occupancy;
  logic                           q_pop;

  assign cfg_ready = 1'b1;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= kfh_pkg::KMER_LEN_RESET;
    end else if (cfg_valid) begin
      kmer_len_r <= cfg_data;
    end
  end

  // The result queue holds two entries. An item may enter only if the queries
  // already in flight, plus this one, will find room when they arrive there.
  assign q_pop       = out_tvalid && out_tready;
  assign q_occupancy = {1'b0, q_level} + 3'(s1_query_r) - 3'(q_pop);
  assign in_tready   = !clr_busy_r && (q_occupancy < 3'd2);

  kfh_window #(
    .MAX_KMER_LEN (MAX_KMER_LEN)
  ) u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .req_type     (in_tuser),
    .base_code    (in_tdata[1:0]),
    .base_invalid (in_tdata[2]),
    .query_kmer   (in_tdata[18:3]),
    .kmer_len     (kmer_len_r),
    .op           (op),
    .idx          (idx)
  );

  // An increment in the second stage writes in the same cycle that the next
  // item reads. The memory returns old data then, so the written value is kept
  // and takes its place when the addresses match.
  assign rd_en = op.inc || op.query;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      s1_inc_r   <= 1'b0;
      s1_query_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      s1_inc_r   <= op.inc;
      s1_query_r <= op.query;
      fwd_hit_r  <= s1_inc_r && rd_en && (s1_idx_r == idx);
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= idx;
    fwd_data_r <= inc_count;
  end

  assign cur_count = fwd_hit_r ? fwd_data_r : rd_data;
  assign inc_count = (cur_count == '1) ? cur_count : cur_count + COUNT_BITS'(1);

  assign wr_en   = clr_busy_r || s1_inc_r;
  assign wr_addr = clr_busy_r ? clr_addr_r : s1_idx_r;
  assign wr_data = clr_busy_r ? '0 : inc_count;

  kfh_ram #(
    .WIDTH  (COUNT_BITS),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // Counts wider than the result field saturate at its maximum.
  assign count_ext = {32'd0, cur_count};
  assign result    = (count_ext > (COUNT_BITS + 32)'(32'hFFFF_FFFF)) ? '1
                   : count_ext[kfh_pkg::RESULT_W-1:0];

  kfh_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_query_r),
    .push_data (result),
    .pop_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .level     (q_level)
  );

endmodule

FILE: hw/rtl/kfh_ram.sv
module kfh_ram #(
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  localparam longint unsigned DEPTH = 64'd1 << ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Read returns the contents before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/kfh_window.sv
module kfh_window #(
  parameter int MAX_KMER_LEN = kfh_pkg::MAX_KMER_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [kfh_pkg::REQ_W-1:0]         req_type,
  input  logic [1:0]                        base_code,
  input  logic                              base_invalid,
  input  logic [kfh_pkg::QUERY_W-1:0]       query_kmer,
  input  logic [kfh_pkg::KMER_LEN_W-1:0]    kmer_len,
  output kfh_pkg::tbl_op_t                  op,
  output logic [2*MAX_KMER_LEN-1:0]         idx
);

  localparam int KMER_W = 2 * MAX_KMER_LEN;
  localparam int LEN_W  = $clog2(MAX_KMER_LEN + 1);

  logic [KMER_W-1:0]  window_r, window_nxt;
  logic [LEN_W-1:0]   run_r, run_nxt;
  logic [LEN_W-1:0]   eff_len;
  logic [KMER_W-1:0]  mask;
  logic [KMER_W+1:0]  shifted;
  logic [KMER_W+15:0] query_ext;
  logic [LEN_W-1:0]   run_inc;

  // Clamp the configured length into 1..MAX_KMER_LEN.
  always_comb begin
    if (kmer_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(kmer_len) > MAX_KMER_LEN) begin
      eff_len = LEN_W'(MAX_KMER_LEN);
    end else begin
      eff_len = LEN_W'(kmer_len);
    end
  end

  always_comb begin
    for (int i = 0; i < KMER_W; i++) begin
      mask[i] = (i < 2 * int'(eff_len));
    end
  end

  assign shifted   = {window_r, base_code};
  assign query_ext = {{KMER_W{1'b0}}, query_kmer};
  assign run_inc   = (run_r < LEN_W'(MAX_KMER_LEN)) ? run_r + LEN_W'(1) : run_r;

  always_comb begin
    window_nxt = window_r;
    run_nxt    = run_r;
    op         = '0;
    idx        = query_ext[KMER_W-1:0] & mask;
    if (accept) begin
      case (kfh_pkg::req_type_t'(req_type))
        kfh_pkg::REQ_BASE: begin
          window_nxt = shifted[KMER_W-1:0];
          idx        = shifted[KMER_W-1:0] & mask;
          if (base_invalid) begin
            run_nxt = '0;
          end else begin
            run_nxt = run_inc;
            op.inc  = (run_inc >= eff_len);
          end
        end
        kfh_pkg::REQ_EOS: begin
          window_nxt = '0;
          run_nxt    = '0;
        end
        kfh_pkg::REQ_QUERY: begin
          op.query = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      run_r    <= '0;
    end else begin
      window_r <= window_nxt;
      run_r    <= run_nxt;
    end
  end

endmodule

FILE: hw/rtl/kfh_outq.sv
module kfh_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [kfh_pkg::RESULT_W-1:0] push_data,
  input  logic                         pop_ready,
  output logic                         out_valid,
  output logic [kfh_pkg::RESULT_W-1:0] out_data,
  output logic [1:0]                   level
);

  logic [kfh_pkg::RESULT_W-1:0] slot_r [2];
  logic                         wr_ptr_r, rd_ptr_r;
  logic [1:0]                   cnt_r;
  logic                         pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid && pop_ready;
  assign level     = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: verif/kmer_frequency_histogram_test.sv
`timescale 1ns / 1ps

module kmer_frequency_histogram_test;

  // Clock and reset. Reset is held low from time zero and then released for good.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Every input of the block holds a known value from time zero.
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  // tdata: base_code[1:0], base_invalid[2], query_kmer[18:3], zero pad [23:19]
  logic [23:0]                    in_tdata = '0;
  // tuser: req_type[1:0]
  logic [kfh_pkg::REQ_W-1:0]      in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // tdata: kmer_count[31:0]
  logic [kfh_pkg::RESULT_W-1:0]   out_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [kfh_pkg::KMER_LEN_W-1:0] cfg_data = '0;

  kmer_frequency_histogram u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // One input item as the stimulus sees it. The gap is the number of idle cycles the
  // sender spends before presenting the item. A held item is not presented until every
  // count that is owed by the block has come back.
  typedef struct {
    kfh_pkg::req_type_t          req;
    logic [1:0]                  code;
    logic                        bad;
    logic [kfh_pkg::QUERY_W-1:0] query;
    int unsigned                 gap;
    bit                          hold;
  } kmer_item_t;

  kmer_item_t pending_q[$];
  kmer_item_t cur_item;
  int unsigned idle_cnt;

  // Shadow of the block: its length register, its base window, the length of the current
  // run of unambiguous bases and the whole histogram. The table starts cleared, just as
  // the block's clearing pass leaves it.
  logic [kfh_pkg::KMER_LEN_W-1:0] kmer_len_cfg = kfh_pkg::KMER_LEN_RESET;
  logic [kfh_pkg::QUERY_W-1:0]    win_reg = '0;
  int unsigned                    run_len = 0;
  bit [kfh_pkg::RESULT_W-1:0]     hist_tbl [0:(1 << kfh_pkg::QUERY_W) - 1];
  bit [kfh_pkg::RESULT_W-1:0]     count_expect_q[$];

  // Coverage tallies for the closing summary.
  int unsigned n_base = 0, n_ambig = 0, n_eos = 0, n_query = 0, n_nonzero = 0, n_ignored = 0;
  int unsigned n_results = 0;
  int unsigned error_cnt = 0;

  // Stall controls; a calm phase runs that side without any idle cycles.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int unsigned stall_left;

  // Lengths swept by the random phases, including both ends of the legal range and the
  // out-of-range settings (zero acts as one, anything above eight acts as eight).
  logic [kfh_pkg::KMER_LEN_W-1:0] len_plan [10] = '{4'd1, 4'd0, 4'd15, 4'd2, 4'd8,
                                                   4'd5, 4'd9, 4'd3, 4'd7, 4'd1};

  function automatic int unsigned eff_len(input logic [kfh_pkg::KMER_LEN_W-1:0] v);
    if (v == '0) return 1;
    if (v > kfh_pkg::MAX_KMER_LEN_DEF) return kfh_pkg::MAX_KMER_LEN_DEF;
    return 32'(v);
  endfunction

  // Low 2*k bits set: the part of a packed k-mer that addresses the table.
  function automatic logic [kfh_pkg::QUERY_W-1:0] kmer_mask(input int unsigned k);
    return kfh_pkg::QUERY_W'((33'h1 << (2 * k)) - 33'h1);
  endfunction

  // Applies one accepted item to the shadow and queues the count a query must return.
  function automatic void histogram_apply(input kmer_item_t it);
    int unsigned                 k;
    logic [kfh_pkg::QUERY_W-1:0] msk;
    logic [kfh_pkg::QUERY_W-1:0] idx;
    k = eff_len(kmer_len_cfg);
    msk = kmer_mask(k);
    case (it.req)
      kfh_pkg::REQ_BASE: begin
        n_base++;
        // Even an ambiguous base shifts in; it only breaks the run.
        win_reg = {win_reg[kfh_pkg::QUERY_W-3:0], it.code};
        if (it.bad) begin
          n_ambig++;
          run_len = 0;
        end else begin
          if (run_len < kfh_pkg::MAX_KMER_LEN_DEF) run_len++;
          if (run_len >= k) begin
            idx = win_reg & msk;
            if (hist_tbl[idx] != '1) hist_tbl[idx]++;
          end
        end
      end
      kfh_pkg::REQ_EOS: begin
        n_eos++;
        win_reg = '0;
        run_len = 0;
      end
      kfh_pkg::REQ_QUERY: begin
        n_query++;
        idx = it.query & msk;
        if (hist_tbl[idx] != '0) n_nonzero++;
        count_expect_q.push_back(hist_tbl[idx]);
      end
      default: begin
        n_ignored++;
      end
    endcase
  endfunction

  task automatic note_error(input string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  function automatic kmer_item_t make_item(input kfh_pkg::req_type_t req,
                                           input logic [1:0] code, input logic bad,
                                           input logic [kfh_pkg::QUERY_W-1:0] query);
    kmer_item_t it;
    it.req = req;
    it.code = code;
    it.bad = bad;
    it.query = query;
    it.gap = tx_calm ? 0 : $urandom_range(0, 15);
    it.hold = 1'b0;
    return it;
  endfunction

  // Sender. The item on the bus is folded into the shadow at the edge that accepts it,
  // and the next item goes out once its gap has run down.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      idle_cnt = 0;
    end else begin
      if (in_tvalid && in_tready) histogram_apply(cur_item);
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() != 0 && idle_cnt >= pending_q[0].gap &&
            !(pending_q[0].hold && count_expect_q.size() != 0)) begin
          cur_item = pending_q.pop_front();
          in_tdata <= {5'b0, cur_item.query, cur_item.bad, cur_item.code};
          in_tuser <= cur_item.req;
          in_tvalid <= 1'b1;
          idle_cnt = 0;
        end else begin
          in_tvalid <= 1'b0;
          if (pending_q.size() != 0) idle_cnt++;
        end
      end
    end
  end

  // Receiver. Each returned count is checked against the oldest one owed, and a fresh
  // stall is drawn after every accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (count_expect_q.size() == 0) begin
          note_error($sformatf("count %0d returned with no query outstanding", out_tdata));
        end else if (out_tdata !== count_expect_q[0]) begin
          note_error($sformatf("kmer_count expected %0d, got %0d",
                               count_expect_q[0], out_tdata));
          void'(count_expect_q.pop_front());
        end else begin
          void'(count_expect_q.pop_front());
        end
        stall_left = rx_calm ? 0 : $urandom_range(0, 15);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Writes the length register; only called while the block has nothing in flight.
  task automatic write_kmer_len(input logic [kfh_pkg::KMER_LEN_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    kmer_len_cfg = v;
    cfg_valid <= 1'b0;
  endtask

  // Waits until every item has gone in and every count has come out, then lets the clock
  // run on so that increments from trailing bases have landed in the table. The check
  // is made at the falling edge, when the sender's outputs have settled.
  task automatic settle();
    do @(negedge clk); while (pending_q.size() != 0 || in_tvalid || count_expect_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Random traffic for one length setting. Bases mostly follow a short repeating motif so
  // that the same k-mers recur and counts climb; queries mostly ask for the k-mer just
  // streamed, with junk above the k-mer width that the block must ignore.
  task automatic queue_random_run(input int unsigned n);
    int unsigned                 made;
    int unsigned                 pick;
    int unsigned                 motif_len;
    int unsigned                 pos;
    logic [kfh_pkg::QUERY_W-1:0] motif;
    logic [kfh_pkg::QUERY_W-1:0] gen_win;
    logic [kfh_pkg::QUERY_W-1:0] msk;
    logic [kfh_pkg::QUERY_W-1:0] q;
    logic [1:0]                  b;
    kmer_item_t                  it;
    made = 0;
    pos = 0;
    gen_win = '0;
    motif = kfh_pkg::QUERY_W'($urandom);
    motif_len = $urandom_range(1, 8);
    msk = kmer_mask(eff_len(kmer_len_cfg));
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        // Unused request type; does not count toward the phase size.
        it = make_item(kfh_pkg::REQ_NONE, 2'($urandom), 1'($urandom),
                       kfh_pkg::QUERY_W'($urandom));
      end else begin
        made++;
        if (pick < 5) begin
          it = make_item(kfh_pkg::REQ_EOS, 2'($urandom), 1'($urandom),
                         kfh_pkg::QUERY_W'($urandom));
          gen_win = '0;
          motif = kfh_pkg::QUERY_W'($urandom);
          motif_len = $urandom_range(1, 8);
          pos = 0;
        end else if (pick < 25) begin
          if ($urandom_range(0, 3) != 0)
            q = (gen_win & msk) | (kfh_pkg::QUERY_W'($urandom) & ~msk);
          else q = kfh_pkg::QUERY_W'($urandom);
          it = make_item(kfh_pkg::REQ_QUERY, 2'($urandom), 1'($urandom), q);
        end else begin
          b = ($urandom_range(0, 9) == 0) ? 2'($urandom) : motif[2*pos +: 2];
          pos = (pos + 1) % motif_len;
          gen_win = {gen_win[kfh_pkg::QUERY_W-3:0], b};
          it = make_item(kfh_pkg::REQ_BASE, b, ($urandom_range(0, 19) == 0),
                         kfh_pkg::QUERY_W'($urandom));
        end
      end
      it.hold = ($urandom_range(0, 39) == 0);
      pending_q.push_back(it);
    end
  endtask

  initial begin
    kmer_item_t it;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset length of eight. The block is still clearing its table,
    // so these items wait on in_tready for the whole clearing pass.
    pending_q.push_back(make_item(kfh_pkg::REQ_QUERY, 2'd3, 1'b1, 16'h0000));
    pending_q.push_back(make_item(kfh_pkg::REQ_QUERY, 2'd0, 1'b0, 16'hFFFF));
    // Eight A bases make the all-zero k-mer once.
    repeat (8) pending_q.push_back(make_item(kfh_pkg::REQ_BASE, 2'd0, 1'b0, 16'hFFFF));
    // The sender holds here until all counts owed so far have returned.
    it = make_item(kfh_pkg::REQ_QUERY, 2'd0, 1'b0, 16'h0000);
    it.hold = 1'b1;
    pending_q.push_back(it);
    // An ambiguous base breaks the run, so the G after it completes no window.
    pending_q.push_back(make_item(kfh_pkg::REQ_BASE, 2'd1, 1'b1, 16'h0000));
    pending_q.push_back(make_item(kfh_pkg::REQ_BASE, 2'd2, 1'b0, 16'h0000));
    pending_q.push_back(make_item(kfh_pkg::REQ_EOS, 2'd3, 1'b1, 16'hFFFF));
    // Eight T bases make the all-ones k-mer once.
    repeat (8) pending_q.push_back(make_item(kfh_pkg::REQ_BASE, 2'd3, 1'b0, 16'h0000));
    pending_q.push_back(make_item(kfh_pkg::REQ_QUERY, 2'd3, 1'b1, 16'hFFFF));
    pending_q.push_back(make_item(kfh_pkg::REQ_NONE, 2'd3, 1'b1, 16'hFFFF));
    pending_q.push_back(make_item(kfh_pkg::REQ_QUERY, 2'd2, 1'b1, 16'h0000));
    settle();

    // Random phases, one per length setting; two of them run the sender or the
    // receiver without stalls.
    foreach (len_plan[i]) begin
      write_kmer_len(len_plan[i]);
      tx_calm = (i == 3);
      rx_calm = (i == 3 || i == 6);
      queue_random_run(58);
      settle();
    end

    // Bounded drain; anything still owed after it is a failure.
    for (int w = 0; w < 20000 && (pending_q.size() != 0 || in_tvalid ||
                                  count_expect_q.size() != 0); w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (count_expect_q.size() != 0)
      note_error($sformatf("%0d counts never returned", count_expect_q.size()));

    $display("Covered %0d bases (%0d ambiguous), %0d sequence ends, %0d ignored items,",
             n_base, n_ambig, n_eos, n_ignored);
    $display("%0d queries (%0d with a nonzero count) over k settings 8,1,0,15,2,8,5,9,3,7,1.",
             n_query, n_nonzero);
    if (error_cnt == 0) begin
      $display("kmer_frequency_histogram verification clean");
    end else begin
      $display("%0d errors", error_cnt);
      $display("kmer_frequency_histogram verification failed");
    end
    $finish;
  end

  // Watchdog: the slowest legal run, clearing pass included, is well under this.
  initial begin
    #4_000_000;
    $display("Timeout with %0d items pending and %0d counts owed",
             pending_q.size(), count_expect_q.size());
    $display("kmer_frequency_histogram verification failed");
    $finish;
  end

endmodule
